/* rtl/qft_pkg.sv */
package qft_pkg;

	localparam int MAX_DELIMITERS  = 8;
	localparam int MAX_QUOTE_PAIRS = 4;
	localparam int MAX_RESULTS     = 3;

	typedef enum logic [1:0] {
		REG_DELIMITER_BYTES = 2'd0,
		REG_QUOTE_PAIRS     = 2'd1,
		REG_ESCAPE_BYTE     = 2'd2,
		REG_KEEP_EMPTY      = 2'd3
	} qft_reg_t;

	typedef enum logic {
		KIND_BYTE = 1'b0,
		KIND_MARK = 1'b1
	} qft_kind_t;

	typedef struct packed {
		logic [63:0] delims;
		logic [63:0] quotes;
		logic [7:0]  esc;
		logic        keep;
	} qft_cfg_t;

	typedef struct packed {
		logic       in_quote;
		logic [7:0] active_close;
		logic       escape_held;
		logic       field_nonempty;
	} qft_state_t;

	typedef struct packed {
		qft_kind_t  kind;
		logic [7:0] out_byte;
		logic       string_done;
		logic       run_last;
	} qft_res_t;

	typedef struct packed {
		logic [1:0]                 count;
		qft_res_t [MAX_RESULTS-1:0] res;
		qft_state_t                 nxt;
	} qft_step_t;

endpackage

/* rtl/qft_step.sv */
module qft_step (
	input  qft_pkg::qft_cfg_t   cfg,
	input  qft_pkg::qft_state_t cur,
	input  logic [7:0]          in_byte,
	input  logic                string_last,
	output qft_pkg::qft_step_t  step
);
	import qft_pkg::*;

	typedef struct packed {
		logic       emit;
		qft_res_t   res;
		qft_state_t st;
	} qft_hb_t;

	function automatic qft_res_t mk_res(qft_kind_t k, logic [7:0] b);
		qft_res_t r;
		r.kind        = k;
		r.out_byte    = (k == KIND_MARK) ? 8'd0 : b;
		r.string_done = 1'b0;
		r.run_last    = 1'b0;
		return r;
	endfunction

	function automatic logic is_delim(logic [7:0] b, logic [63:0] delims);
		logic       hit;
		logic       stop;
		logic [7:0] d;
		hit  = 1'b0;
		stop = (b == 8'd0);
		for (int i = 0; i < MAX_DELIMITERS; i++) begin
			d = delims[8*i +: 8];
			if (!stop) begin
				if (d == 8'd0) begin
					stop = 1'b1;
				end else if (d == b) begin
					hit  = 1'b1;
					stop = 1'b1;
				end
			end
		end
		return hit;
	endfunction

	function automatic qft_hb_t handle_byte(logic [7:0] b, logic may_hold, qft_state_t s,
			qft_cfg_t c);
		qft_hb_t    h;
		logic       check;
		logic       found;
		logic       stop;
		logic [7:0] op;
		logic [7:0] cl;
		h     = '0;
		h.st  = s;
		check = 1'b0;
		found = 1'b0;
		stop  = (b == 8'd0);
		cl    = 8'd0;
		for (int i = 0; i < MAX_QUOTE_PAIRS; i++) begin
			op = c.quotes[16*i +: 8];
			if (!stop) begin
				if (op == 8'd0) begin
					stop = 1'b1;
				end else if (op == b) begin
					found = 1'b1;
					cl    = c.quotes[16*i+8 +: 8];
					stop  = 1'b1;
				end
			end
		end
		if (!s.in_quote) begin
			check = 1'b1;
			if (found) begin
				h.st.in_quote     = 1'b1;
				h.st.active_close = cl;
			end
		end else if (may_hold && c.esc != 8'd0 && b == c.esc) begin
			h.st.escape_held = 1'b1;
			return h;
		end else if (s.active_close != 8'd0 && b == s.active_close) begin
			h.st.in_quote     = 1'b0;
			h.st.active_close = 8'd0;
			check             = 1'b1;
		end
		if (check && is_delim(b, c.delims)) begin
			h.emit              = c.keep | s.field_nonempty;
			h.res               = mk_res(KIND_MARK, 8'd0);
			h.st.field_nonempty = 1'b0;
		end else begin
			h.emit              = 1'b1;
			h.res               = mk_res(KIND_BYTE, b);
			h.st.field_nonempty = 1'b1;
		end
		return h;
	endfunction

	logic       dle;
	logic       consumed;
	qft_state_t st;
	qft_hb_t    hb;
	logic [1:0] n;
	qft_res_t [MAX_RESULTS-1:0] res;

	assign dle = (cfg.delims[7:0] == 8'd0);

	always_comb begin
		st       = cur;
		n        = 2'd0;
		res      = '0;
		consumed = 1'b0;
		hb       = '0;
		if (st.escape_held) begin
			st.escape_held = 1'b0;
			if (!dle && st.in_quote && st.active_close != 8'd0 && in_byte == st.active_close) begin
				res[n]            = mk_res(KIND_BYTE, in_byte);
				n                 = n + 2'd1;
				st.field_nonempty = 1'b1;
				consumed          = 1'b1;
			end else if (dle) begin
				res[n]            = mk_res(KIND_BYTE, cfg.esc);
				n                 = n + 2'd1;
				st.field_nonempty = 1'b1;
			end else begin
				hb = handle_byte(cfg.esc, 1'b0, st, cfg);
				st = hb.st;
				if (hb.emit) begin
					res[n] = hb.res;
					n      = n + 2'd1;
				end
			end
		end
		if (!consumed) begin
			if (dle) begin
				res[n]            = mk_res(KIND_BYTE, in_byte);
				n                 = n + 2'd1;
				st.field_nonempty = 1'b1;
			end else begin
				hb = handle_byte(in_byte, !string_last, st, cfg);
				st = hb.st;
				if (hb.emit) begin
					res[n] = hb.res;
					n      = n + 2'd1;
				end
			end
		end
		if (string_last) begin
			if (st.field_nonempty) begin
				res[n] = mk_res(KIND_MARK, 8'd0);
				n      = n + 2'd1;
			end
			st = '0;
		end
		if (n != 2'd0) begin
			res[n - 2'd1].run_last    = 1'b1;
			res[n - 2'd1].string_done = string_last;
		end
		step.count = n;
		step.res   = res;
		step.nxt   = st;
	end

endmodule

/* rtl/qft_out_buf.sv */
module qft_out_buf (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  logic                                      load,
	input  logic [1:0]                                load_count,
	input  qft_pkg::qft_res_t [qft_pkg::MAX_RESULTS-1:0] load_res,
	output logic                                      can_load,
	output logic                                      m_tvalid,
	input  logic                                      m_tready,
	output logic [7:0]                                m_tdata,  // out_byte
	output logic [1:0]                                m_tuser,  // kind, run_last
	output logic                                      m_tlast   // string_done
);
	import qft_pkg::*;

	qft_res_t [MAX_RESULTS-1:0] ent_q;
	logic [1:0]                 rd_q;
	logic [1:0]                 rem_q;
	qft_res_t                   head;
	logic                       pop;

	always_comb begin
		case (rd_q)
			2'd0:    head = ent_q[0];
			2'd1:    head = ent_q[1];
			2'd2:    head = ent_q[2];
			default: head = ent_q[0];
		endcase
	end

	assign m_tvalid = (rem_q != 2'd0);
	assign pop      = m_tvalid & m_tready;
	assign can_load = (rem_q == 2'd0) || (rem_q == 2'd1 && m_tready);
	assign m_tdata  = head.out_byte;
	assign m_tuser  = {head.run_last, head.kind};
	assign m_tlast  = head.string_done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q  <= 2'd0;
			rem_q <= 2'd0;
		end else if (load) begin
			rd_q  <= 2'd0;
			rem_q <= load_count;
		end else if (pop) begin
			rd_q  <= rd_q + 2'd1;
			rem_q <= rem_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			ent_q <= load_res;
		end
	end

endmodule

/* rtl/quoted_field_tokenizer.sv */
// Splits a byte stream into fields. Each accepted byte (s_tlast ends the string) yields
// zero to three output beats: field bytes (kind 0) and end-of-field marks (kind 1), with
// run_last on the final beat a byte caused and m_tlast on the final beat of a string.
// Delimiters, quote pairs, escape byte and keep-empty come from the write port and
// must be written while the block is idle. A byte is registered, then decoded
// combinationally against all delimiter and quote compares into a three-entry result
// buffer; one byte per cycle is taken while each byte yields at most one beat and
// m_tready is high, otherwise the output side sets the rate, one beat per ready cycle.
module quoted_field_tokenizer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [63:0] cfg_data,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // in_byte
	input  logic        s_tlast,   // string_last
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // out_byte
	output logic [1:0]  m_tuser,   // kind, run_last
	output logic        m_tlast    // string_done
);
	import qft_pkg::*;

	qft_cfg_t   cfg_q;
	qft_state_t st_q;
	qft_step_t  step;
	logic       v_s1;
	logic [7:0] byte_s1;
	logic       last_s1;
	logic       can_load;
	logic       advance;

	assign advance  = v_s1 & can_load;
	assign s_tready = !v_s1 || can_load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			case (qft_reg_t'(cfg_index))
				REG_DELIMITER_BYTES: cfg_q.delims <= cfg_data;
				REG_QUOTE_PAIRS:     cfg_q.quotes <= cfg_data;
				REG_ESCAPE_BYTE:     cfg_q.esc    <= cfg_data[7:0];
				REG_KEEP_EMPTY:      cfg_q.keep   <= cfg_data[0];
				default:             cfg_q        <= cfg_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			st_q <= '0;
		end else begin
			if (s_tvalid && s_tready) begin
				v_s1 <= 1'b1;
			end else if (advance) begin
				v_s1 <= 1'b0;
			end
			if (advance) begin
				st_q <= step.nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

	qft_step u_step (
		.cfg         (cfg_q),
		.cur         (st_q),
		.in_byte     (byte_s1),
		.string_last (last_s1),
		.step        (step)
	);

	qft_out_buf u_out_buf (
		.clk        (clk),
		.arst_n     (arst_n),
		.load       (advance),
		.load_count (step.count),
		.load_res   (step.res),
		.can_load   (can_load),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser),
		.m_tlast    (m_tlast)
	);

`ifndef ASSERT_OFF
	a_escape_in_quote: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.escape_held |-> st_q.in_quote)
		else $error("escape held outside quotes");

	a_close_clear: assert property (@(posedge clk) disable iff (!arst_n)
		!st_q.in_quote |-> (st_q.active_close == 8'd0))
		else $error("closing byte left set outside quotes");

	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && !can_load) |=> (v_s1 && $stable(byte_s1) && $stable(st_q)))
		else $error("stage one lost a byte while the buffer was busy");
`endif

endmodule

/* bench/tb_quoted_field_tokenizer.sv */
module tb_quoted_field_tokenizer;
	import qft_pkg::*;

	localparam int CYCLE_LIMIT  = 200000;
	localparam int DRAIN_CYCLES = 8;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} in_beat_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [63:0] cfg_data;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;   // in_byte
	logic        s_tlast;   // string_last
	logic        m_tvalid;
	logic        m_tready;
	logic [7:0]  m_tdata;   // out_byte
	logic [1:0]  m_tuser;   // kind, run_last
	logic        m_tlast;   // string_done

	quoted_field_tokenizer uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tlast(s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.m_tlast(m_tlast)
	);

	// shadow registers and tokenizer state
	logic [63:0] cfg_delims = '0;
	logic [63:0] cfg_quotes = '0;
	logic [7:0]  cfg_esc    = '0;
	logic        cfg_keep   = 1'b0;
	logic        quoted      = 1'b0;
	logic [7:0]  close_byte  = '0;
	logic        esc_pending = 1'b0;
	logic        field_open  = 1'b0;

	in_beat_t byte_q[$];
	qft_res_t token_q[$];
	qft_res_t step_beats[$];
	in_beat_t next_in;
	qft_res_t want;

	bit    in_taken = 1'b0;
	bit    failed = 1'b0;
	int    cycles = 0;
	int    in_gap = 0;
	int    out_hold = 0;
	int    gap_pct = 0;
	int    stall_pct = 0;
	string special_pool = ",;|:\"'()[]\\ #";

	initial clk = 1'b0;
	always #5 clk = ~clk;

	function automatic bit delim_hit(logic [7:0] b);
		if (b == 8'd0) return 1'b0;
		for (int i = 0; i < MAX_DELIMITERS; i++) begin
			if (cfg_delims[8*i +: 8] == 8'd0) return 1'b0;
			if (cfg_delims[8*i +: 8] == b) return 1'b1;
		end
		return 1'b0;
	endfunction

	function automatic bit open_hit(logic [7:0] b, output logic [7:0] cl);
		cl = 8'd0;
		if (b == 8'd0) return 1'b0;
		for (int i = 0; i < MAX_QUOTE_PAIRS; i++) begin
			if (cfg_quotes[16*i +: 8] == 8'd0) return 1'b0;
			if (cfg_quotes[16*i +: 8] == b) begin
				cl = cfg_quotes[16*i+8 +: 8];
				return 1'b1;
			end
		end
		return 1'b0;
	endfunction

	task automatic push_beat(qft_kind_t k, logic [7:0] b);
		qft_res_t r;
		if (step_beats.size() >= MAX_RESULTS) return;
		r.kind        = k;
		r.out_byte    = (k == KIND_MARK) ? 8'd0 : b;
		r.string_done = 1'b0;
		r.run_last    = 1'b0;
		step_beats.insert(step_beats.size(), r);
	endtask

	task automatic scan_byte(logic [7:0] b, bit may_hold);
		bit         check;
		logic [7:0] cl;
		check = 1'b0;
		if (!quoted) begin
			check = 1'b1;
			if (open_hit(b, cl)) begin
				quoted     = 1'b1;
				close_byte = cl;
			end
		end else if (may_hold && cfg_esc != 8'd0 && b == cfg_esc) begin
			esc_pending = 1'b1;
			return;
		end else if (close_byte != 8'd0 && b == close_byte) begin
			quoted     = 1'b0;
			close_byte = 8'd0;
			check      = 1'b1;
		end
		if (check && delim_hit(b)) begin
			if (cfg_keep || field_open) push_beat(KIND_MARK, 8'd0);
			field_open = 1'b0;
		end else begin
			push_beat(KIND_BYTE, b);
			field_open = 1'b1;
		end
	endtask

	// work out the beats one accepted byte causes and queue them
	task automatic tokenize_byte(logic [7:0] b, logic last);
		bit       taken;
		qft_res_t tail;
		step_beats.delete();
		taken = 1'b0;
		if (esc_pending) begin
			esc_pending = 1'b0;
			if (cfg_delims[7:0] != 8'd0 && quoted && close_byte != 8'd0 && b == close_byte) begin
				push_beat(KIND_BYTE, b);
				field_open = 1'b1;
				taken = 1'b1;
			end else if (cfg_delims[7:0] == 8'd0) begin
				push_beat(KIND_BYTE, cfg_esc);
				field_open = 1'b1;
			end else begin
				scan_byte(cfg_esc, 1'b0);
			end
		end
		if (!taken) begin
			if (cfg_delims[7:0] == 8'd0) begin
				push_beat(KIND_BYTE, b);
				field_open = 1'b1;
			end else begin
				scan_byte(b, !last);
			end
		end
		if (last) begin
			if (field_open) push_beat(KIND_MARK, 8'd0);
			quoted      = 1'b0;
			close_byte  = 8'd0;
			esc_pending = 1'b0;
			field_open  = 1'b0;
		end
		if (step_beats.size() > 0) begin
			tail = step_beats[step_beats.size() - 1];
			tail.run_last    = 1'b1;
			tail.string_done = last;
			step_beats[step_beats.size() - 1] = tail;
		end
		foreach (step_beats[k]) token_q.insert(token_q.size(), step_beats[k]);
	endtask

	function automatic int draw_gap(int pct);
		if ($urandom_range(99) >= pct) return 0;
		if ($urandom_range(9) == 0) return $urandom_range(40, 15);
		return $urandom_range(3, 1);
	endfunction

	function automatic logic [7:0] pick_special();
		if ($urandom_range(1)) return special_pool[$urandom_range(special_pool.len() - 1)];
		return 8'($urandom_range(255, 1));
	endfunction

	function automatic logic [7:0] pick_byte();
		int sel;
		int nd;
		int nq;
		nd = 0;
		while (nd < MAX_DELIMITERS && cfg_delims[8*nd +: 8] != 8'd0) nd++;
		nq = 0;
		while (nq < MAX_QUOTE_PAIRS && cfg_quotes[16*nq +: 8] != 8'd0) nq++;
		sel = $urandom_range(99);
		if (sel < 20 && nd > 0) return cfg_delims[8*$urandom_range(nd - 1) +: 8];
		if (sel >= 20 && sel < 35 && nq > 0) return cfg_quotes[16*$urandom_range(nq - 1) +: 8];
		if (sel >= 35 && sel < 50 && nq > 0)
			return cfg_quotes[16*$urandom_range(nq - 1) + 8 +: 8];
		if (sel >= 50 && sel < 60) return cfg_esc;
		if (sel >= 60 && sel < 80) return 8'($urandom_range(255));
		return 8'h61 + 8'($urandom_range(25));
	endfunction

	task automatic queue_text(string s, bit fin);
		in_beat_t e;
		for (int i = 0; i < s.len(); i++) begin
			e.data = s[i];
			e.last = fin && (i == s.len() - 1);
			byte_q.insert(byte_q.size(), e);
		end
	endtask

	task automatic queue_raw(logic [7:0] b, bit fin);
		in_beat_t e;
		e.data = b;
		e.last = fin;
		byte_q.insert(byte_q.size(), e);
	endtask

	// wait for the block to drain, then let it go quiet
	task automatic settle();
		do @(posedge clk); while (byte_q.size() != 0 || s_tvalid || token_q.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(qft_reg_t idx, logic [63:0] v);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= v;
		case (idx)
			REG_DELIMITER_BYTES: begin
				cfg_delims = v;
			end
			REG_QUOTE_PAIRS: begin
				cfg_quotes = v;
			end
			REG_ESCAPE_BYTE: begin
				cfg_esc = v[7:0];
			end
			default: begin
				cfg_keep = v[0];
			end
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// upper bits of the narrow registers carry junk that must be ignored
	task automatic load_config(logic [63:0] d, logic [63:0] q, logic [7:0] e, logic k);
		write_reg(REG_DELIMITER_BYTES, d);
		write_reg(REG_QUOTE_PAIRS, q);
		write_reg(REG_ESCAPE_BYTE, {$urandom, 24'($urandom_range(16777215)), e});
		write_reg(REG_KEEP_EMPTY, {$urandom, 31'($urandom_range(2147483647)), k});
	endtask

	task automatic random_config();
		logic [63:0] d;
		logic [63:0] q;
		int          nd;
		int          nq;
		d = '0;
		q = '0;
		nd = ($urandom_range(9) == 0) ? 0 : $urandom_range(MAX_DELIMITERS, 1);
		for (int k = 0; k < nd; k++) d[8*k +: 8] = pick_special();
		if (nd < MAX_DELIMITERS - 1 && $urandom_range(1))
			for (int k = nd + 1; k < MAX_DELIMITERS; k++) d[8*k +: 8] = 8'($urandom_range(255));
		nq = $urandom_range(MAX_QUOTE_PAIRS);
		for (int k = 0; k < nq; k++) begin
			q[16*k +: 8]     = pick_special();
			q[16*k + 8 +: 8] = ($urandom_range(7) == 0) ? 8'd0 : pick_special();
		end
		if (nq < MAX_QUOTE_PAIRS - 1 && $urandom_range(1))
			for (int k = nq + 1; k < MAX_QUOTE_PAIRS; k++)
				q[16*k +: 16] = 16'($urandom_range(65535));
		load_config(d, q, ($urandom_range(3) == 0) ? 8'd0 : pick_special(),
			1'($urandom_range(1)));
	endtask

	// sender: advance to the next byte once the current beat is taken
	always @(negedge clk) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else if (!s_tvalid || in_taken) begin
			if (in_gap > 0) begin
				s_tvalid <= 1'b0;
				in_gap--;
			end else if (byte_q.size() > 0) begin
				next_in = byte_q.pop_front();
				s_tdata  <= next_in.data;
				s_tlast  <= next_in.last;
				s_tvalid <= 1'b1;
				in_gap = draw_gap(gap_pct);
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// receiver: hold off at random
	always @(negedge clk) begin
		if (out_hold > 0) begin
			m_tready <= 1'b0;
			out_hold--;
		end else begin
			m_tready <= 1'b1;
			out_hold = draw_gap(stall_pct);
		end
	end

	always @(posedge clk) begin
		in_taken = s_tvalid && s_tready;
		if (arst_n) begin
			cycles++;
			if (cycles > CYCLE_LIMIT) begin
				$display("quoted_field_tokenizer verification failed");
				$finish;
			end else begin
				if (in_taken) tokenize_byte(s_tdata, s_tlast);
				if (m_tvalid && m_tready) begin
					if (token_q.size() == 0) begin
						$error("unexpected beat: out_byte %0h kind %0d", m_tdata, m_tuser[0]);
						failed = 1'b1;
					end else begin
						want = token_q.pop_front();
						if (m_tuser[0] !== want.kind) begin
							$error("kind: expected %0d, actual %0d", want.kind, m_tuser[0]);
							failed = 1'b1;
						end
						if (m_tdata !== want.out_byte) begin
							$error("out_byte: expected %0h, actual %0h", want.out_byte, m_tdata);
							failed = 1'b1;
						end
						if (m_tlast !== want.string_done) begin
							$error("string_done: expected %0d, actual %0d", want.string_done,
								m_tlast);
							failed = 1'b1;
						end
						if (m_tuser[1] !== want.run_last) begin
							$error("run_last: expected %0d, actual %0d", want.run_last, m_tuser[1]);
							failed = 1'b1;
						end
					end
				end
			end
		end
	end

	initial begin
		int n;
		int len;
		arst_n    = 1'b0;
		cfg_we    = 1'b0;
		cfg_index = '0;
		cfg_data  = '0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		s_tlast   = 1'b0;
		m_tready  = 1'b0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		gap_pct   = 30;
		stall_pct = 30;

		// plain quotes, backslash escape, keep empty fields
		load_config(64'h3B2C, 64'h2928_2222, 8'h5C, 1'b1);
		queue_text("a,,b;", 1'b1);
		queue_text("\"\\\"\"", 1'b1);
		queue_text("(\\", 1'b1);
		queue_raw(8'h00, 1'b0);
		queue_raw(8'hFF, 1'b1);
		settle();

		// quote byte doubling as delimiter, open without close, escape equal to close
		load_config(64'h7C2C, 64'h2727_005B_7C7C, 8'h27, 1'b0);
		queue_text("a|b|c", 1'b1);
		queue_text(",", 1'b1);
		queue_text("[,x", 1'b1);
		queue_text("'a'b", 1'b1);
		queue_text("'a'", 1'b0);
		settle();
		write_reg(REG_ESCAPE_BYTE, 64'h5C);
		queue_text("b", 1'b1);
		settle();

		// no delimiters: everything passes through
		load_config(64'h0, 64'h2222, 8'h5C, 1'b1);
		queue_text("\\\"", 1'b1);

		for (int p = 0; p < 6; p++) begin
			settle();
			if (p == 1)
				load_config({64{1'b1}}, {64{1'b1}}, 8'hFF, 1'b1);
			else
				random_config();
			if (p == 2) write_reg(REG_DELIMITER_BYTES, 64'h0);
			gap_pct   = (p == 0) ? 0 : $urandom_range(50, 10);
			stall_pct = (p == 0) ? 0 : $urandom_range(50, 10);
			n = 0;
			while (n < 20) begin
				len = ($urandom_range(7) == 0) ? 1 : $urandom_range(10, 2);
				for (int k = 0; k < len; k++) queue_raw(pick_byte(), k == len - 1);
				n += len;
			end
		end
		settle();

		if (failed)
			$display("quoted_field_tokenizer verification failed");
		else
			$display("quoted_field_tokenizer verification clean");
		$finish;
	end

endmodule
